/* rtl/psar_pkg.sv */
// Shared types and constants of the parabolic stop-and-reverse tracker.
`default_nettype none

package psar_pkg;

    localparam int PRICE_WIDTH_DEF = 32;
    localparam int ACCEL_WIDTH_DEF = 16;

    localparam int ACC_INC_RESET  = 1311;
    localparam int ACC_CEIL_RESET = 13107;

    localparam int CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ACC_INC  = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ACC_CEIL = 1'b1;

    typedef struct packed {
        logic has_result;
        logic trend_long;
        logic status;
    } t_res_flags;

endpackage

`default_nettype wire

/* rtl/psar_move.sv */
// Moves the stop level toward the extreme point by the acceleration, rounded down.
`default_nettype none

module psar_move #(
    parameter int PRICE_WIDTH = psar_pkg::PRICE_WIDTH_DEF,
    parameter int ACCEL_WIDTH = psar_pkg::ACCEL_WIDTH_DEF
) (
    input  wire logic [PRICE_WIDTH-1:0] i_cur,
    input  wire logic [PRICE_WIDTH-1:0] i_target,
    input  wire logic [ACCEL_WIDTH-1:0] i_accel,
    output logic      [PRICE_WIDTH-1:0] o_moved
);
    import psar_pkg::*;

    logic                               neg;
    logic [PRICE_WIDTH-1:0]             mag;
    logic [PRICE_WIDTH+ACCEL_WIDTH-1:0] prod;
    logic [PRICE_WIDTH-1:0]             quot;
    logic                               rem;

    always_comb begin
        neg  = i_target < i_cur;
        mag  = neg ? (i_cur - i_target) : (i_target - i_cur);
        prod = {{ACCEL_WIDTH{1'b0}}, mag} * {{PRICE_WIDTH{1'b0}}, i_accel};
        quot = prod[PRICE_WIDTH+ACCEL_WIDTH-1:ACCEL_WIDTH];
        rem  = |prod[ACCEL_WIDTH-1:0];
        // A downward move rounds toward minus infinity, so a remainder adds one more step.
        if (neg) begin
            o_moved = i_cur - quot - PRICE_WIDTH'(rem);
        end else begin
            o_moved = i_cur + quot;
        end
    end

endmodule

`default_nettype wire

/* rtl/psar_step.sv */
// Tracker state and the combinational update of one bar.
`default_nettype none

module psar_step #(
    parameter int PRICE_WIDTH = psar_pkg::PRICE_WIDTH_DEF,
    parameter int ACCEL_WIDTH = psar_pkg::ACCEL_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_advance,
    input  wire logic                   i_first,
    input  wire logic [PRICE_WIDTH-1:0] i_high,
    input  wire logic [PRICE_WIDTH-1:0] i_low,
    input  wire logic [ACCEL_WIDTH-1:0] i_acc_inc,
    input  wire logic [ACCEL_WIDTH-1:0] i_acc_ceil,
    output psar_pkg::t_res_flags        o_flags,
    output logic      [PRICE_WIDTH-1:0] o_sar
);
    import psar_pkg::*;

    localparam logic [1:0] BARS_NONE = 2'd0;
    localparam logic [1:0] BARS_ONE  = 2'd1;
    localparam logic [1:0] BARS_TWO  = 2'd2;

    logic [PRICE_WIDTH-1:0] r_sar, n_sar;
    logic [PRICE_WIDTH-1:0] r_ext, n_ext;
    logic [ACCEL_WIDTH-1:0] r_acc, n_acc;
    logic                   r_long, n_long;
    logic [1:0]             r_bars, n_bars;
    logic [PRICE_WIDTH-1:0] r_low1, r_low2, r_high1, r_high2;

    logic [1:0]             bars;
    logic                   cfg_ok;
    logic                   long0;
    logic [PRICE_WIDTH-1:0] ext0, sar0, sar1, clamp1, sar2, ext1;
    logic [ACCEL_WIDTH-1:0] acc0, acc1;
    logic [ACCEL_WIDTH:0]   acc_sum;
    logic                   new_ext, flip;

    psar_move #(
        .PRICE_WIDTH(PRICE_WIDTH),
        .ACCEL_WIDTH(ACCEL_WIDTH)
    ) u_move (
        .i_cur   (sar0),
        .i_target(ext0),
        .i_accel (acc0),
        .o_moved (sar1)
    );

    always_comb begin
        bars   = i_first ? BARS_NONE : r_bars;
        cfg_ok = (i_acc_inc != '0) && (i_acc_ceil > i_acc_inc);

        if (bars == BARS_ONE) begin
            long0 = ({1'b0, r_high1} + {1'b0, r_low1}) <= ({1'b0, i_high} + {1'b0, i_low});
            ext0  = long0 ? r_high1 : r_low1;
            sar0  = long0 ? r_low1 : r_high1;
            acc0  = i_acc_inc;
        end else begin
            long0 = r_long;
            ext0  = r_ext;
            sar0  = r_sar;
            acc0  = r_acc;
        end

        if (long0) begin
            clamp1  = ((bars == BARS_TWO) && (sar1 > r_low2)) ? r_low2 : sar1;
            sar2    = (clamp1 > r_low1) ? r_low1 : clamp1;
            new_ext = i_high > ext0;
        end else begin
            clamp1  = ((bars == BARS_TWO) && (sar1 < r_high2)) ? r_high2 : sar1;
            sar2    = (clamp1 < r_high1) ? r_high1 : clamp1;
            new_ext = i_low < ext0;
        end

        acc_sum = {1'b0, acc0} + {1'b0, i_acc_inc};
        if (new_ext && (acc0 < i_acc_ceil)) begin
            acc1 = (acc_sum > {1'b0, i_acc_ceil}) ? i_acc_ceil : acc_sum[ACCEL_WIDTH-1:0];
        end else begin
            acc1 = acc0;
        end
        ext1 = new_ext ? (long0 ? i_high : i_low) : ext0;

        flip = long0 ? (i_low < sar2) : (i_high > sar2);
        if (flip) begin
            n_sar  = ext1;
            n_ext  = long0 ? i_low : i_high;
            n_acc  = i_acc_inc;
            n_long = !long0;
        end else begin
            n_sar  = sar2;
            n_ext  = ext1;
            n_acc  = acc1;
            n_long = long0;
        end
        n_bars = (bars == BARS_NONE) ? BARS_ONE : BARS_TWO;

        o_flags.has_result = bars != BARS_NONE;
        o_flags.trend_long = cfg_ok && n_long;
        o_flags.status     = !cfg_ok;
        o_sar              = cfg_ok ? n_sar : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bars <= BARS_NONE;
        end else if (i_advance) begin
            r_bars <= n_bars;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_high2 <= r_high1;
            r_low2  <= r_low1;
            r_high1 <= i_high;
            r_low1  <= i_low;
            if (bars != BARS_NONE) begin
                r_sar  <= n_sar;
                r_ext  <= n_ext;
                r_acc  <= n_acc;
                r_long <= n_long;
            end
        end
    end

    a_first_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_first |=> r_bars == BARS_ONE)
        else $error("A first bar did not restart the series.");

    a_bars_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && !i_first && r_bars != BARS_NONE |=> r_bars == BARS_TWO)
        else $error("Bar count did not saturate.");

    a_result_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance |=> !i_first |-> o_flags.has_result)
        else $error("A bar following another bar gave no result.");

endmodule

`default_nettype wire

/* rtl/parabolic_sar_tracker_top.sv */
// Top level of the parabolic stop-and-reverse tracker with stream and configuration ports.
//
// Bars enter on the slave stream: s_axis_tdata carries high_price and low_price,
// s_axis_tuser carries first_bar. Results leave on the master stream: m_axis_tdata
// carries sar_value, m_axis_tuser carries trend_is_long and status.
// The configuration channel writes the acceleration increment (index 0) and the
// acceleration ceiling (index 1); it is always ready and should only be written while
// no word is in flight.
// A word accepted at a clock edge is registered in the input register and worked on there;
// once it advances, its result is registered in the output register and is valid on the
// master side. One word is accepted in every cycle unless the receiver stalls; the limit
// is the single multiply and compare chain of the stop update, which close the state loop.
// The first bar of a series gives no result; every later bar gives one result.
// After reset no series is open, both registers hold their default values, and the
// pipeline is empty. When the receiver stalls, the result stays in the output
// register and one more word waits in the input register; then s_axis_tready drops.
`default_nettype none

module parabolic_sar_tracker_top #(
    parameter int PRICE_WIDTH = psar_pkg::PRICE_WIDTH_DEF,
    parameter int ACCEL_WIDTH = psar_pkg::ACCEL_WIDTH_DEF,
    parameter int S_TDATA_W   = ((2 * PRICE_WIDTH + 7) / 8) * 8,
    parameter int M_TDATA_W   = ((PRICE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [psar_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [ACCEL_WIDTH-1:0]               i_cfg_data,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // Fields from bit 0: high_price, low_price, zero fill.
    input  wire logic [S_TDATA_W-1:0]                 s_axis_tdata,
    // Fields from bit 0: first_bar.
    input  wire logic [0:0]                           s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // Fields from bit 0: sar_value, zero fill.
    output logic      [M_TDATA_W-1:0]                 m_axis_tdata,
    // Fields from bit 0: trend_is_long, status.
    output logic      [1:0]                           m_axis_tuser
);
    import psar_pkg::*;

    localparam logic [ACCEL_WIDTH-1:0] STEP_RST = ACCEL_WIDTH'(ACC_INC_RESET);
    localparam logic [ACCEL_WIDTH-1:0] MAX_RST  = ACCEL_WIDTH'(ACC_CEIL_RESET);

    logic [ACCEL_WIDTH-1:0] r_acc_inc;
    logic [ACCEL_WIDTH-1:0] r_acc_ceil;

    logic                   r_in_valid;
    logic                   r_in_first;
    logic [PRICE_WIDTH-1:0] r_in_high;
    logic [PRICE_WIDTH-1:0] r_in_low;

    logic                   r_out_valid;
    logic [PRICE_WIDTH-1:0] r_out_sar;
    logic                   r_out_long;
    logic                   r_out_status;

    t_res_flags             flags;
    logic [PRICE_WIDTH-1:0] step_sar;
    logic                   advance;
    logic                   in_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_inc  <= STEP_RST;
            r_acc_ceil <= MAX_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_ACC_INC) begin
                r_acc_inc <= i_cfg_data;
            end
            if (i_cfg_index == CFG_ACC_CEIL) begin
                r_acc_ceil <= i_cfg_data;
            end
        end
    end

    assign advance       = r_in_valid && (!flags.has_result || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_first <= s_axis_tuser[0];
            r_in_high  <= s_axis_tdata[PRICE_WIDTH-1:0];
            r_in_low   <= s_axis_tdata[2*PRICE_WIDTH-1:PRICE_WIDTH];
        end
    end

    psar_step #(
        .PRICE_WIDTH(PRICE_WIDTH),
        .ACCEL_WIDTH(ACCEL_WIDTH)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_first   (r_in_first),
        .i_high    (r_in_high),
        .i_low     (r_in_low),
        .i_acc_inc (r_acc_inc),
        .i_acc_ceil(r_acc_ceil),
        .o_flags   (flags),
        .o_sar     (step_sar)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && flags.has_result) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && flags.has_result) begin
            r_out_sar    <= step_sar;
            r_out_long   <= flags.trend_long;
            r_out_status <= flags.status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out_sar);
    assign m_axis_tuser  = {r_out_status, r_out_long};

    a_status_clears_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status |-> (r_out_sar == '0) && !r_out_long)
        else $error("A result with bad settings carried a stop level or trend.");

    a_input_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid)
        else $error("A waiting bar was dropped.");

    a_no_phantom_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid && !(advance && flags.has_result) |=> !r_out_valid)
        else $error("A result appeared without a bar that causes one.");

endmodule

`default_nettype wire
